@@ rtl/ekrt_pkg.sv @@
// package for the expiring keyed request table
// holds word types, operation codes and default sizes; no dependencies
package ekrt_pkg;

  localparam int unsigned NumTypesDef = 8;
  localparam int unsigned EntriesDef  = 16;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ParamW = 32;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [2:0] {
    OpAdd    = 3'd0,
    OpRemove = 3'd1,
    OpQuery  = 3'd2,
    OpClear  = 3'd3,
    OpTick   = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]        operation;
    logic [3:0]        req_type;
    logic [KeyW-1:0]   target_key;
    logic [TimeW-1:0]  valid_time;
    logic [ParamW-1:0] req_param;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [TimeW-1:0]  time_left;
    logic [ParamW-1:0] stored_param;
  } rsp_t;

endpackage

@@ rtl/ekrt_ram.sv @@
// generic single port ram with registered read
// no dependencies
module ekrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                           wdata_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/expiring_keyed_request_table.sv @@
// expiring keyed request table top level, depends on ekrt_pkg and ekrt_ram
// done_o ends add, remove and query after each slot of the type is read and checked
// through the one ram port, then StWr and on a hit for add or query StTkChk; clear only
// StWr, a type out of range only StRd, an unknown code none; tick visits every slot
// busy is still high with done_o; the next word is taken back in idle; no result stall
// reset clears the valid bits at once, so every table starts empty
module expiring_keyed_request_table
  import ekrt_pkg::*;
#(
  parameter int unsigned NumTypes = NumTypesDef,
  parameter int unsigned Entries  = EntriesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned Slots = NumTypes * Entries;
  localparam int unsigned AW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned EW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned TW = (NumTypes > 1) ? $clog2(NumTypes) : 1;
  localparam int unsigned DW = KeyW + TimeW + ParamW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRd    = 3'd1;
  localparam logic [2:0] StChk   = 3'd2;
  localparam logic [2:0] StWr    = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;
  localparam logic [2:0] StTkRd  = 3'd5;
  localparam logic [2:0] StTkChk = 3'd6;

  logic [2:0]       st_q, st_d;
  req_t             req_q;
  logic [Slots-1:0] val_q, val_d;
  logic [EW:0]      idx_q, idx_d;
  logic [AW:0]      tix_q, tix_d;
  logic             hit_q, hit_d, free_q, free_d;
  logic [EW-1:0]    hidx_q, hidx_d, fidx_q, fidx_d, vidx_q, vidx_d;
  logic [TimeW-1:0] bt_q, bt_d;
  logic [KeyW-1:0]  bk_q, bk_d;
  logic             vnew_q, vnew_d;
  rsp_t             rsp_q, rsp_d;

  logic             we;
  logic [AW-1:0]    addr;
  logic [DW-1:0]    wdata, rdata;
  logic [KeyW-1:0]  rkey;
  logic [TimeW-1:0] rtime;
  logic [ParamW-1:0] rpar;
  logic [AW-1:0]    base;
  logic [AW-1:0]    cur;
  logic             type_ok;

  assign rkey  = rdata[DW-1 -: KeyW];
  assign rtime = rdata[TimeW+ParamW-1 -: TimeW];
  assign rpar  = rdata[ParamW-1:0];
  assign type_ok = {1'b0, req_q.req_type} < 5'(NumTypes);
  assign base  = AW'(32'(req_q.req_type[TW-1:0]) * Entries);
  assign cur   = base + AW'(idx_q[EW-1:0]);

  ekrt_ram #(.Width(DW), .Depth(Slots)) u_ram (
    .clk_i,
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign busy   = st_q != StIdle;
  assign done_o = st_q == StDone;
  assign rsp_o  = rsp_q;

  always_comb begin
    st_d = st_q; val_d = val_q; idx_d = idx_q; tix_d = tix_q;
    hit_d = hit_q; free_d = free_q; hidx_d = hidx_q; fidx_d = fidx_q;
    vidx_d = vidx_q; bt_d = bt_q; bk_d = bk_q; vnew_d = vnew_q; rsp_d = rsp_q;
    we = 1'b0; addr = cur; wdata = rdata;
    case (st_q)
      StIdle: begin
        if (start) begin
          idx_d = '0; tix_d = '0; hit_d = 1'b0; free_d = 1'b0;
          vnew_d = 1'b1; rsp_d = '0;
          bt_d = req_i.valid_time; bk_d = req_i.target_key;
          case (req_i.operation)
            OpAdd, OpRemove, OpQuery: st_d = StRd;
            OpClear: st_d = StWr;
            OpTick:  st_d = StTkRd;
            default: st_d = StDone;
          endcase
        end
      end
      StRd: begin
        if (!type_ok) st_d = StDone;
        else st_d = StChk;
      end
      StChk: begin
        if (val_q[cur]) begin
          if (!hit_q && rkey == req_q.target_key) begin
            hit_d = 1'b1; hidx_d = idx_q[EW-1:0];
          end
          if (rtime < bt_q || (rtime == bt_q && rkey < bk_q)) begin
            bt_d = rtime; bk_d = rkey; vidx_d = idx_q[EW-1:0]; vnew_d = 1'b0;
          end
        end else if (!free_q) begin
          free_d = 1'b1; fidx_d = idx_q[EW-1:0];
        end
        if (idx_q == (EW+1)'(Entries - 1)) begin
          st_d = StWr; idx_d = '0;
        end else begin
          idx_d = idx_q + 1'b1; st_d = StRd;
        end
      end
      StWr: begin
        st_d = StDone;
        case (req_q.operation)
          OpClear: begin
            if (type_ok) begin
              for (int i = 0; i < Entries; i++) val_d[base + AW'(i)] = 1'b0;
            end
          end
          OpRemove: if (hit_q) val_d[base + AW'(hidx_q)] = 1'b0;
          OpQuery: begin
            if (hit_q) begin
              addr = base + AW'(hidx_q);
              st_d = StTkChk;
            end
          end
          OpAdd: begin
            if (hit_q) begin
              st_d = StTkChk;
              addr = base + AW'(hidx_q);
            end else if (free_q || !vnew_q) begin
              we = 1'b1;
              addr = base + AW'(free_q ? fidx_q : vidx_q);
              wdata = {req_q.target_key, req_q.valid_time, req_q.req_param};
              val_d[addr] = 1'b1;
            end
          end
          default: ;
        endcase
      end
      StTkRd: begin
        addr = tix_q[AW-1:0];
        st_d = StTkChk;
      end
      StTkChk: begin
        if (req_q.operation == OpQuery) begin
          addr = base + AW'(hidx_q);
          rsp_d = '{found: 1'b1, time_left: rtime, stored_param: rpar};
          st_d = StDone;
        end else if (req_q.operation == OpAdd) begin
          addr = base + AW'(hidx_q);
          we = 1'b1;
          wdata = {rkey, req_q.valid_time, rpar};
          st_d = StDone;
        end else begin
          addr = tix_q[AW-1:0];
          if (val_q[addr]) begin
            we = 1'b1;
            wdata = {rkey, rtime - TimeW'(rtime != '0), rpar};
            if (rtime <= TimeW'(1)) val_d[addr] = 1'b0;
          end
          if (tix_q == (AW+1)'(Slots - 1)) st_d = StDone;
          else begin
            tix_d = tix_q + 1'b1; st_d = StTkRd;
          end
        end
      end
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      val_q <= '0;
    end else begin
      st_q <= st_d;
      val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && start) req_q <= req_i;
    idx_q <= idx_d; tix_q <= tix_d; hit_q <= hit_d; free_q <= free_d;
    hidx_q <= hidx_d; fidx_q <= fidx_d; vidx_q <= vidx_d;
    bt_q <= bt_d; bk_q <= bk_d; vnew_q <= vnew_d; rsp_q <= rsp_d;
  end

endmodule

@@ tb/expiring_keyed_request_table_tb.sv @@
// testbench for expiring_keyed_request_table: directed and random words
// checked against an in-bench model of the per-type expiring tables
// depends on ekrt_pkg and the rtl of the block
module expiring_keyed_request_table_tb;
  import ekrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NT = NumTypesDef;
  localparam int unsigned NE = EntriesDef;
  localparam int unsigned NS = NT * NE;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  expiring_keyed_request_table DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic              tbl_valid [NS];
  logic [KeyW-1:0]   tbl_key   [NS];
  logic [TimeW-1:0]  tbl_time  [NS];
  logic [ParamW-1:0] tbl_param [NS];
  rsp_t expected_rsp [$];
  int   errors = 0;
  int   idle_pct = 0;
  int   words_sent = 0;
  int   queries_hit = 0;
  int   evictions = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int find_entry(input int t, input logic [KeyW-1:0] k);
    for (int i = 0; i < NE; i++)
      if (tbl_valid[t*NE+i] && tbl_key[t*NE+i] == k) return t*NE+i;
    return -1;
  endfunction

  function automatic rsp_t table_apply(input req_t r);
    rsp_t o;
    int t;
    int s;
    int victim;
    logic [TimeW-1:0] bt;
    logic [KeyW-1:0] bk;
    o = '0;
    t = r.req_type;
    case (r.operation)
      OpAdd: if (t < NT) begin
        s = find_entry(t, r.target_key);
        if (s >= 0) tbl_time[s] = r.valid_time;
        else begin
          for (int i = 0; i < NE && s < 0; i++)
            if (!tbl_valid[t*NE+i]) s = t*NE+i;
          if (s >= 0) begin
            tbl_valid[s] = 1'b1;
            tbl_key[s] = r.target_key;
            tbl_time[s] = r.valid_time;
            tbl_param[s] = r.req_param;
          end else begin
            evictions++;
            bt = r.valid_time;
            bk = r.target_key;
            victim = -1;
            for (int i = 0; i < NE; i++)
              if (tbl_time[t*NE+i] < bt ||
                  (tbl_time[t*NE+i] == bt && tbl_key[t*NE+i] < bk)) begin
                bt = tbl_time[t*NE+i];
                bk = tbl_key[t*NE+i];
                victim = t*NE+i;
              end
            if (victim >= 0) begin
              tbl_key[victim] = r.target_key;
              tbl_time[victim] = r.valid_time;
              tbl_param[victim] = r.req_param;
            end
          end
        end
      end
      OpRemove: if (t < NT) begin
        s = find_entry(t, r.target_key);
        if (s >= 0) tbl_valid[s] = 1'b0;
      end
      OpQuery: if (t < NT) begin
        s = find_entry(t, r.target_key);
        if (s >= 0) begin
          o.found = 1'b1;
          o.time_left = tbl_time[s];
          o.stored_param = tbl_param[s];
          queries_hit++;
        end
      end
      OpClear: if (t < NT)
        for (int i = 0; i < NE; i++) tbl_valid[t*NE+i] = 1'b0;
      OpTick:
        for (int i = 0; i < NS; i++) if (tbl_valid[i]) begin
          if (tbl_time[i] != 0) tbl_time[i] = tbl_time[i] - 1;
          if (tbl_time[i] == 0) tbl_valid[i] = 1'b0;
        end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [3:0] t,
                           input logic [KeyW-1:0] k, input logic [TimeW-1:0] tm,
                           input logic [ParamW-1:0] p);
    req_t r;
    r = '{op, t, k, tm, p};
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_rsp.push_back(table_apply(r));
    words_sent++;
  endtask

  always @(posedge clk_i) if (rst_ni && done_o) begin
    if (expected_rsp.size() == 0) report("result word with none expected");
    else begin
      rsp_t e;
      e = expected_rsp.pop_front();
      if (rsp_o.found !== e.found)
        report($sformatf("found %b exp %b", rsp_o.found, e.found));
      if (rsp_o.time_left !== e.time_left)
        report($sformatf("time_left %h exp %h", rsp_o.time_left, e.time_left));
      if (rsp_o.stored_param !== e.stored_param)
        report($sformatf("param %h exp %h", rsp_o.stored_param, e.stored_param));
    end
  end

  task automatic drain();
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2, 3: return {$urandom, $urandom};
      default: return KeyW'($urandom_range(23));
    endcase
  endfunction

  function automatic logic [TimeW-1:0] pick_time();
    case ($urandom_range(7))
      0: return '0;
      1: return TimeMax;
      2: return $urandom;
      default: return TimeW'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic test_directed();
    send_word(OpQuery, 0, '0, '0, '0);
    send_word(OpAdd, 0, '1, TimeMax, '1);
    send_word(OpQuery, 0, '1, '0, '0);
    send_word(OpAdd, 0, '1, 3, 32'h5);
    send_word(OpQuery, 0, '1, '0, '0);
    send_word(OpAdd, 7, '0, '0, 32'hA5A5A5A5);
    send_word(OpQuery, 7, '0, '0, '0);
    send_word(OpAdd, 8, 64'h1, 5, 32'h1);
    send_word(OpQuery, 8, 64'h1, '0, '0);
    send_word(OpAdd, 15, 64'h1, 5, 32'h1);
    send_word(OpRemove, 0, 64'h1234, '0, '0);
    send_word(OpTick, 11, '0, '0, '0);
    send_word(OpQuery, 7, '0, '0, '0);
    send_word(OpQuery, 0, '1, '0, '0);
    send_word(OpRemove, 0, '1, '0, '0);
    send_word(OpQuery, 0, '1, '0, '0);
    send_word(3'd5, 1, '0, '0, '0);
    send_word(3'd6, 1, '0, '0, '0);
    send_word(3'd7, 1, '0, '0, '0);
    send_word(OpAdd, 2, 64'h9, 9, 9);
    send_word(OpClear, 2, '0, '0, '0);
    send_word(OpQuery, 2, 64'h9, '0, '0);
    send_word(OpClear, 9, '0, '0, '0);
    drain();
  endtask

  // overfill type 3 at max time so the tie rule decides, then type 4
  task automatic test_eviction();
    for (int i = 0; i < NE + 3; i++)
      send_word(OpAdd, 3, 64'hFFFF_0000_0000_0000 - KeyW'(i), TimeMax, ParamW'(i));
    for (int i = 0; i < NE + 3; i++)
      send_word(OpQuery, 3, 64'hFFFF_0000_0000_0000 - KeyW'(i), '0, '0);
    for (int i = 0; i < NE + 4; i++)
      send_word(OpAdd, 4, KeyW'($urandom_range(40)), TimeW'($urandom_range(1, 4)),
                $urandom);
    for (int i = 0; i < 8; i++)
      send_word(OpQuery, 4, KeyW'($urandom_range(40)), '0, '0);
    drain();
  endtask

  task automatic test_random(input int n, input int pct);
    int u;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      u = $urandom_range(99);
      send_word(u < 40 ? OpAdd : u < 48 ? OpRemove : u < 82 ? OpQuery :
                u < 85 ? OpClear : u < 95 ? OpTick : 3'($urandom_range(5, 7)),
                $urandom_range(99) < 85 ? 4'($urandom_range(2)) : 4'($urandom),
                pick_key(), pick_time(), $urandom);
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_eviction();
    test_random(350, 0);
    test_random(350, 77);
    test_random(350, 0);
    test_random(350, 38);
    repeat (2 * NS + 20) @(posedge clk_i);
    $display("%0d words sent, %0d query hits, %0d full-table adds; idle 0/38/77 pct",
             words_sent, queries_hit, evictions);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
